>>> sv/pidmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pidmc_pkg;

  localparam int FRAC_BITS      = 8;
  localparam int GAIN_W         = 16;
  localparam int DUTY_W         = 8;
  localparam int CFG_INDEX_W    = 3;
  localparam int CFG_DATA_W     = GAIN_W;
  // integral term is held inside +/- PWM_LIMIT * 2^8, PWM_LIMIT at most 65535
  localparam int INTEG_W        = 25;
  // duty_right, dir_right, duty_left, dir_left padded to whole bytes
  localparam int OUT_FIELDS_W   = 2 * (DUTY_W + 1);
  localparam int OUT_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int PWM_LIMIT_DEF  = 255;
  localparam int SPEED_BITS_DEF = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PROP_GAIN_RIGHT  = 3'd0,
    REG_INTEG_GAIN_RIGHT = 3'd1,
    REG_DERIV_GAIN_RIGHT = 3'd2,
    REG_PROP_GAIN_LEFT   = 3'd3,
    REG_INTEG_GAIN_LEFT  = 3'd4,
    REG_DERIV_GAIN_LEFT  = 3'd5,
    REG_POLARITY_RIGHT   = 3'd6,
    REG_POLARITY_LEFT    = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic              polarity;
  } lane_cfg_t;

  // load enables of the three pipeline stages
  typedef struct packed {
    logic ld_err;
    logic ld_prod;
    logic ld_out;
  } pipe_ctl_t;

endpackage

`default_nettype wire

>>> sv/pidmc_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module pidmc_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               wr_en,
  input  wire logic [pidmc_pkg::CFG_INDEX_W-1:0]  wr_index,
  input  wire logic [pidmc_pkg::CFG_DATA_W-1:0]   wr_data,
  output pidmc_pkg::lane_cfg_t                    cfg_right,
  output pidmc_pkg::lane_cfg_t                    cfg_left
);

  pidmc_pkg::reg_index_t idx;

  assign idx = pidmc_pkg::reg_index_t'(wr_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_right <= '{prop_gain: '0, integ_gain: '0, deriv_gain: '0, polarity: 1'b1};
      cfg_left  <= '{prop_gain: '0, integ_gain: '0, deriv_gain: '0, polarity: 1'b1};
    end else if (wr_en) begin
      case (idx)
        pidmc_pkg::REG_PROP_GAIN_RIGHT:  cfg_right.prop_gain  <= wr_data;
        pidmc_pkg::REG_INTEG_GAIN_RIGHT: cfg_right.integ_gain <= wr_data;
        pidmc_pkg::REG_DERIV_GAIN_RIGHT: cfg_right.deriv_gain <= wr_data;
        pidmc_pkg::REG_PROP_GAIN_LEFT:   cfg_left.prop_gain   <= wr_data;
        pidmc_pkg::REG_INTEG_GAIN_LEFT:  cfg_left.integ_gain  <= wr_data;
        pidmc_pkg::REG_DERIV_GAIN_LEFT:  cfg_left.deriv_gain  <= wr_data;
        pidmc_pkg::REG_POLARITY_RIGHT:   cfg_right.polarity   <= wr_data[0];
        pidmc_pkg::REG_POLARITY_LEFT:    cfg_left.polarity    <= wr_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/pidmc_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module pidmc_lane #(
  parameter int PWM_LIMIT  = pidmc_pkg::PWM_LIMIT_DEF,
  parameter int SPEED_BITS = pidmc_pkg::SPEED_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire pidmc_pkg::pipe_ctl_t                  ctl,
  input  wire pidmc_pkg::lane_cfg_t                  cfg,
  input  wire logic signed [SPEED_BITS-1:0]          target,
  input  wire logic signed [SPEED_BITS-1:0]          measured,
  output logic [pidmc_pkg::DUTY_W-1:0]               duty,
  output logic                                       dir
);

  localparam int EW   = SPEED_BITS + 1;   // error
  localparam int DW   = SPEED_BITS + 2;   // error difference
  localparam int GW   = pidmc_pkg::GAIN_W + 1;
  localparam int PW   = EW + GW;
  localparam int DPW  = DW + GW;
  localparam int AW   = SPEED_BITS + 21;  // room for the sum of three terms
  localparam int FB   = pidmc_pkg::FRAC_BITS;
  localparam int IW   = pidmc_pkg::INTEG_W;
  localparam int DUW  = pidmc_pkg::DUTY_W;
  localparam longint LIM_VAL = longint'(PWM_LIMIT) * (longint'(1) << FB);
  localparam logic signed [AW-1:0] LIM     = AW'(LIM_VAL);
  localparam logic signed [AW-1:0] NEG_LIM = -LIM;

  function automatic logic signed [AW-1:0] clamp_lim(input logic signed [AW-1:0] x);
    logic signed [AW-1:0] r;
    if (x > LIM) r = LIM;
    else if (x < NEG_LIM) r = NEG_LIM;
    else r = x;
    return r;
  endfunction

  // stage 1: error
  logic signed [EW-1:0]  err_q;
  // stage 2: products
  logic signed [EW-1:0]  last_err;
  logic signed [DW-1:0]  diff;
  logic signed [PW-1:0]  p_prod;
  logic signed [PW-1:0]  i_prod;
  logic signed [DPW-1:0] d_prod;
  // stage 3: accumulate and clamp
  logic signed [IW-1:0]  integ;
  logic signed [AW-1:0]  integ_next;
  logic signed [AW-1:0]  sum;
  logic signed [AW-1:0]  mag;
  logic                  neg;

  always_ff @(posedge clk) begin
    if (ctl.ld_err) begin
      err_q <= {target[SPEED_BITS-1], target} - {measured[SPEED_BITS-1], measured};
    end
  end

  assign diff = {err_q[EW-1], err_q} - {last_err[EW-1], last_err};

  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      p_prod <= err_q * $signed({1'b0, cfg.prop_gain});
      i_prod <= err_q * $signed({1'b0, cfg.integ_gain});
      d_prod <= diff * $signed({1'b0, cfg.deriv_gain});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_err <= '0;
    end else if (ctl.ld_prod) begin
      last_err <= err_q;
    end
  end

  assign integ_next = clamp_lim(AW'(integ) + AW'(i_prod));
  assign sum        = clamp_lim(AW'(p_prod) + integ_next + AW'(d_prod));
  assign neg        = sum[AW-1];
  assign mag        = neg ? -sum : sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= '0;
    end else if (ctl.ld_out) begin
      integ <= integ_next[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      dir <= neg ? ~cfg.polarity : cfg.polarity;
      // duty saturates at full scale when the limit is above it
      if (mag[AW-1:FB+DUW] != '0) duty <= '1;
      else duty <= mag[FB+DUW-1:FB];
    end
  end

endmodule

`default_nettype wire

>>> sv/dual_pid_motor_speed_control_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Two PID wheel-speed loops (right, left) evaluated once per input item. Each input item
// carries both setpoints and measured speeds; each result item carries a duty magnitude and
// a direction level per wheel. The block takes one item per clock while s_axis_tready is
// high; each result passes a three-stage pipeline (error subtract, gain multiplies,
// integral accumulate with clamp and output saturation), and every stage keeps moving
// while later ones hold, so a stalled output only backs up once all three
// stages are full. Gains are unsigned Q8.8, the integral is clamped to +/- PWM_LIMIT in
// term units, and the duty is the clamped sum truncated toward zero, capped at 255. The user
// must write gains and polarity via the cfg port while no item is in flight (not enforced).
module dual_pid_motor_speed_control_core #(
  parameter int PWM_LIMIT  = pidmc_pkg::PWM_LIMIT_DEF,
  parameter int SPEED_BITS = pidmc_pkg::SPEED_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   s_axis_tvalid,
  output logic                                        s_axis_tready,
  // target_right, measured_right, target_left, measured_left, zero pad
  input  wire logic [((4*SPEED_BITS+7)/8)*8-1:0]      s_axis_tdata,
  output logic                                        m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  // duty_right, dir_right, duty_left, dir_left, zero pad
  output logic [pidmc_pkg::OUT_TDATA_W-1:0]           m_axis_tdata,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [pidmc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [pidmc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int S = SPEED_BITS;

  pidmc_pkg::lane_cfg_t cfg_right;
  pidmc_pkg::lane_cfg_t cfg_left;
  pidmc_pkg::pipe_ctl_t ctl;

  logic valid_err;
  logic valid_prod;
  logic ready_err;
  logic ready_prod;
  logic ready_out;

  logic [pidmc_pkg::DUTY_W-1:0] duty_right;
  logic [pidmc_pkg::DUTY_W-1:0] duty_left;
  logic                         dir_right;
  logic                         dir_left;

  assign cfg_ready = 1'b1;

  pidmc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (cfg_valid),
    .wr_index  (cfg_index),
    .wr_data   (cfg_data),
    .cfg_right (cfg_right),
    .cfg_left  (cfg_left)
  );

  // each stage loads when it is empty or its content moves on
  assign ready_out     = ~m_axis_tvalid | m_axis_tready;
  assign ready_prod    = ~valid_prod | ready_out;
  assign ready_err     = ~valid_err | ready_prod;
  assign s_axis_tready = ready_err;

  assign ctl.ld_err  = s_axis_tvalid & ready_err;
  assign ctl.ld_prod = valid_err & ready_prod;
  assign ctl.ld_out  = valid_prod & ready_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_err     <= 1'b0;
      valid_prod    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (ready_err)  valid_err     <= s_axis_tvalid;
      if (ready_prod) valid_prod    <= valid_err;
      if (ready_out)  m_axis_tvalid <= valid_prod;
    end
  end

  pidmc_lane #(
    .PWM_LIMIT  (PWM_LIMIT),
    .SPEED_BITS (SPEED_BITS)
  ) u_lane_right (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .cfg      (cfg_right),
    .target   ($signed(s_axis_tdata[S-1:0])),
    .measured ($signed(s_axis_tdata[2*S-1:S])),
    .duty     (duty_right),
    .dir      (dir_right)
  );

  pidmc_lane #(
    .PWM_LIMIT  (PWM_LIMIT),
    .SPEED_BITS (SPEED_BITS)
  ) u_lane_left (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .cfg      (cfg_left),
    .target   ($signed(s_axis_tdata[3*S-1:2*S])),
    .measured ($signed(s_axis_tdata[4*S-1:3*S])),
    .duty     (duty_left),
    .dir      (dir_left)
  );

  assign m_axis_tdata = pidmc_pkg::OUT_TDATA_W'({dir_left, duty_left, dir_right, duty_right});

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 500000;
  localparam longint TERM_LIMIT =
    longint'(pidmc_pkg::PWM_LIMIT_DEF) * (longint'(1) << pidmc_pkg::FRAC_BITS);

  typedef struct packed {
    logic [pidmc_pkg::DUTY_W-1:0] duty_right;
    logic                         dir_right;
    logic [pidmc_pkg::DUTY_W-1:0] duty_left;
    logic                         dir_left;
  } drive_t;

  logic clk;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [pidmc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [pidmc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [pidmc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // lane 0 is right, lane 1 is left
  pidmc_pkg::lane_cfg_t lane_cfg [2];
  longint integ_acc [2];
  longint prev_err [2];
  drive_t pending_drive_q [$];

  int mismatch_count = 0;
  int cycle_count = 0;
  int tx_gap_pct = 0;
  int rx_stall_pct = 0;
  int hold_req = 0;

  dual_pid_motor_speed_control_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic longint clamp_term(input longint x);
    if (x > TERM_LIMIT) return TERM_LIMIT;
    if (x < -TERM_LIMIT) return -TERM_LIMIT;
    return x;
  endfunction

  function automatic void lane_step(input int ln, input logic signed [15:0] tgt,
                                    input logic signed [15:0] meas,
                                    output logic [pidmc_pkg::DUTY_W-1:0] duty,
                                    output logic dir);
    longint err;
    longint sum;
    longint mag;
    err = longint'(tgt) - longint'(meas);
    integ_acc[ln] = clamp_term(integ_acc[ln] + err * longint'(lane_cfg[ln].integ_gain));
    sum = err * longint'(lane_cfg[ln].prop_gain) + integ_acc[ln]
        + (err - prev_err[ln]) * longint'(lane_cfg[ln].deriv_gain);
    sum = clamp_term(sum);
    prev_err[ln] = err;
    // zero sum counts as forward drive
    if (sum < 0) begin
      dir = ~lane_cfg[ln].polarity;
      mag = -sum;
    end else begin
      dir = lane_cfg[ln].polarity;
      mag = sum;
    end
    mag = mag >>> pidmc_pkg::FRAC_BITS;
    if (mag > 255) mag = 255;
    duty = mag[pidmc_pkg::DUTY_W-1:0];
  endfunction

  function automatic drive_t compute_drive(input logic [15:0] tr, input logic [15:0] mr,
                                           input logic [15:0] tl, input logic [15:0] ml);
    drive_t res;
    lane_step(0, tr, mr, res.duty_right, res.dir_right);
    lane_step(1, tl, ml, res.duty_left, res.dir_left);
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin
    drive_t exp_drv;
    drive_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.duty_right = m_axis_tdata[7:0];
      got.dir_right  = m_axis_tdata[8];
      got.duty_left  = m_axis_tdata[16:9];
      got.dir_left   = m_axis_tdata[17];
      if (pending_drive_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected item: duty_r=%0d dir_r=%0d duty_l=%0d dir_l=%0d",
                   got.duty_right, got.dir_right, got.duty_left, got.dir_left);
      end else begin
        exp_drv = pending_drive_q.pop_front();
        if (got.duty_right !== exp_drv.duty_right || got.dir_right !== exp_drv.dir_right ||
            got.duty_left !== exp_drv.duty_left || got.dir_left !== exp_drv.dir_left) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch at %0t: exp duty_r=%0d dir_r=%0d duty_l=%0d dir_l=%0d,",
                     $realtime, exp_drv.duty_right, exp_drv.dir_right, exp_drv.duty_left,
                     exp_drv.dir_left,
                     " got duty_r=%0d dir_r=%0d duty_l=%0d dir_l=%0d",
                     got.duty_right, got.dir_right, got.duty_left, got.dir_left);
        end
      end
    end
  end

  // output side: random stalls plus the long hold-off on request
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        m_axis_tready <= 1'b0;
        repeat (n - 1) @(posedge clk);
      end else if ($urandom_range(0, 99) < rx_stall_pct) begin
        n = gap_len();
        m_axis_tready <= 1'b0;
        repeat (n - 1) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_speeds(input logic [15:0] tr, input logic [15:0] mr,
                             input logic [15:0] tl, input logic [15:0] ml);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < tx_gap_pct) gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {ml, tl, mr, tr};
    do @(posedge clk); while (!s_axis_tready);
    pending_drive_q.push_back(compute_drive(tr, mr, tl, ml));
  endtask

  task automatic send_random_item();
    logic [15:0] v [4];
    int t;
    for (int ln = 0; ln < 2; ln++) begin
      if ($urandom_range(0, 3) != 0) begin
        // tracking case: measured speed close to the setpoint
        t = int'($urandom_range(0, 60000)) - 30000;
        v[2*ln] = t[15:0];
        t = t + int'($urandom_range(0, 600)) - 300;
        v[2*ln+1] = t[15:0];
      end else begin
        v[2*ln] = 16'($urandom);
        v[2*ln+1] = 16'($urandom);
      end
    end
    send_speeds(v[0], v[1], v[2], v[3]);
  endtask

  task automatic wait_drained();
    while (pending_drive_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input pidmc_pkg::reg_index_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      pidmc_pkg::REG_PROP_GAIN_RIGHT:  lane_cfg[0].prop_gain = val;
      pidmc_pkg::REG_INTEG_GAIN_RIGHT: lane_cfg[0].integ_gain = val;
      pidmc_pkg::REG_DERIV_GAIN_RIGHT: lane_cfg[0].deriv_gain = val;
      pidmc_pkg::REG_PROP_GAIN_LEFT:   lane_cfg[1].prop_gain = val;
      pidmc_pkg::REG_INTEG_GAIN_LEFT:  lane_cfg[1].integ_gain = val;
      pidmc_pkg::REG_DERIV_GAIN_LEFT:  lane_cfg[1].deriv_gain = val;
      pidmc_pkg::REG_POLARITY_RIGHT:   lane_cfg[0].polarity = val[0];
      pidmc_pkg::REG_POLARITY_LEFT:    lane_cfg[1].polarity = val[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_gains(input logic [15:0] kp_r, input logic [15:0] ki_r,
                               input logic [15:0] kd_r, input logic [15:0] kp_l,
                               input logic [15:0] ki_l, input logic [15:0] kd_l,
                               input logic pol_r, input logic pol_l);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    write_reg(pidmc_pkg::REG_PROP_GAIN_RIGHT, kp_r);
    write_reg(pidmc_pkg::REG_INTEG_GAIN_RIGHT, ki_r);
    write_reg(pidmc_pkg::REG_DERIV_GAIN_RIGHT, kd_r);
    write_reg(pidmc_pkg::REG_PROP_GAIN_LEFT, kp_l);
    write_reg(pidmc_pkg::REG_INTEG_GAIN_LEFT, ki_l);
    write_reg(pidmc_pkg::REG_DERIV_GAIN_LEFT, kd_l);
    write_reg(pidmc_pkg::REG_POLARITY_RIGHT, {15'd0, pol_r});
    write_reg(pidmc_pkg::REG_POLARITY_LEFT, {15'd0, pol_l});
  endtask

  // all gains zero after reset: every sum is zero, dir follows polarity
  task automatic test_reset_state();
    send_speeds(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_speeds(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_speeds(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
  endtask

  task automatic test_directed_cases();
    // tiny gain: an error of one gives a sum below one duty step
    program_gains(16'h0001, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 1'b1, 1'b1);
    send_speeds(16'd0, 16'd1, 16'd1, 16'd0);
    send_speeds(16'd5, 16'd5, 16'hfffe, 16'hfffe);
    send_speeds(16'hffff, 16'd0, 16'd0, 16'hffff);
    // unity proportional, moderate integral and derivative, reversed polarity
    program_gains(16'h0100, 16'h0080, 16'h0040, 16'h0100, 16'h0080, 16'h0040, 1'b0, 1'b0);
    send_speeds(16'd10, 16'd0, 16'd0, 16'd10);
    send_speeds(16'd100, 16'd0, 16'd0, 16'd100);
    send_speeds(16'd0, 16'd200, 16'd200, 16'd0);
    send_speeds(16'd300, 16'd0, 16'd0, 16'd300);
    send_speeds(16'd0, 16'd0, 16'd0, 16'd0);
    send_speeds(16'd0, 16'd5, 16'd5, 16'd0);
    // largest gains with the widest errors, integral pinned at the clamp
    program_gains(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1, 1'b0);
    send_speeds(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_speeds(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_speeds(16'h1234, 16'h1234, 16'h8000, 16'h8000);
    send_speeds(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    // no integral gain: the held integral alone drives the output
    program_gains(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1);
    send_speeds(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_speeds(16'd0, 16'd0, 16'd0, 16'd0);
    program_gains(16'h0100, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000, 1'b0, 1'b1);
    send_speeds(16'd0, 16'd40, 16'd40, 16'd0);
  endtask

  task automatic test_output_backpressure();
    program_gains(16'h0080, 16'h0010, 16'h0020, 16'h0100, 16'h0004, 16'h0000, 1'b1, 1'b0);
    tx_gap_pct = 0;
    rx_stall_pct = 0;
    hold_req = 200;
    repeat (40) send_random_item();
  endtask

  task automatic test_random_traffic();
    logic [15:0] g [6];
    for (int phase = 0; phase < 4; phase++) begin
      for (int k = 0; k < 6; k++) begin
        case (phase)
          0: g[k] = 16'($urandom_range(0, 600));
          1: g[k] = 16'($urandom);
          2: g[k] = (k % 3 == 1) ? 16'($urandom) : 16'($urandom_range(0, 64));
          default: g[k] = 16'hffff;
        endcase
      end
      program_gains(g[0], g[1], g[2], g[3], g[4], g[5], 1'($urandom), 1'($urandom));
      case (phase)
        0: begin tx_gap_pct = 30; rx_stall_pct = 30; end
        1: begin tx_gap_pct = 20; rx_stall_pct = 20; end
        2: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
        default: begin tx_gap_pct = 50; rx_stall_pct = 50; end
      endcase
      repeat (148) send_random_item();
    end
  endtask

  initial begin
    for (int ln = 0; ln < 2; ln++) begin
      lane_cfg[ln] = '0;
      lane_cfg[ln].polarity = 1'b1;
      integ_acc[ln] = 0;
      prev_err[ln] = 0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_directed_cases();
    test_output_backpressure();
    test_random_traffic();
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
